>>> rtl/core/lbc_pkg.sv
package lbc_pkg;

  localparam int CACHE_SLOTS  = 32;
  localparam int DEVICE_COUNT = 16;
  localparam int REF_MAX      = 255;

  // Slot index width, link width (holds the null marker) and count width.
  localparam int SW = $clog2(CACHE_SLOTS);
  localparam int LW = 6;
  localparam int CW = 6;
  localparam int RW = 8;

  localparam logic [LW-1:0] NIL = 6'd63;

  localparam logic [2:0] CMD_GET     = 3'd0;
  localparam logic [2:0] CMD_GET_NF  = 3'd1;
  localparam logic [2:0] CMD_RELEASE = 3'd2;
  localparam logic [2:0] CMD_DIRTY   = 3'd3;
  localparam logic [2:0] CMD_INVAL   = 3'd4;

  localparam logic [2:0] KIND_HIT    = 3'd0;
  localparam logic [2:0] KIND_FILL   = 3'd1;
  localparam logic [2:0] KIND_ALLOC  = 3'd2;
  localparam logic [2:0] KIND_NOSLOT = 3'd3;
  localparam logic [2:0] KIND_WB     = 3'd4;
  localparam logic [2:0] KIND_DONE   = 3'd5;

  localparam int FL_USE   = 0;
  localparam int FL_VALID = 1;
  localparam int FL_DIRTY = 2;
  localparam int FL_BUSY  = 3;

  typedef struct packed {
    logic [3:0]    dev;
    logic [31:0]   blk;
    logic [3:0]    flags;
    logic [RW-1:0] refs;
    logic [LW-1:0] newer;
    logic [LW-1:0] older;
    logic [LW-1:0] flink;
  } entry_t;

  typedef enum logic [3:0] {
    ST_CLEAR, ST_IDLE, ST_SCAN, ST_FREE_RD, ST_EVICT_RD, ST_EVICT_CHK, ST_SLOT_CHK,
    ST_INV_RD, ST_INV_CHK, ST_UNL_A, ST_UNL_B, ST_PUSH, ST_FRONT, ST_INV_FREE, ST_EMIT
  } st_t;

  typedef enum logic [1:0] {
    OP_HIT, OP_BIND, OP_INV
  } op_t;

endpackage

>>> rtl/core/lbc_intf.sv
interface lbc_req_if import lbc_pkg::*; ();
  logic        valid;
  logic        ready;
  logic [2:0]  command;
  logic [3:0]  device_id;
  logic [31:0] block_number;
  logic [4:0]  slot;

  modport source (output valid, command, device_id, block_number, slot, input ready);
  modport sink (input valid, command, device_id, block_number, slot, output ready);
endinterface

interface lbc_rsp_if import lbc_pkg::*; ();
  logic          valid;
  logic          ready;
  logic [2:0]    kind;
  logic [4:0]    out_slot;
  logic [3:0]    out_device;
  logic [31:0]   out_block;
  logic          last;
  logic [31:0]   hit_count;
  logic [31:0]   miss_count;
  logic [CW-1:0] cached_count;
  logic [CW-1:0] dirty_count;

  modport source (output valid, kind, out_slot, out_device, out_block, last, hit_count,
                  miss_count, cached_count, dirty_count, input ready);
  modport sink (input valid, kind, out_slot, out_device, out_block, last, hit_count,
                miss_count, cached_count, dirty_count, output ready);
endinterface

>>> rtl/core/lru_block_buffer_cache.sv
// Directory of a block buffer cache with least-recently-used replacement.
// Requests arrive on in_req (valid/ready); each request gives one or more
// results on out_rsp, the final one flagged by last. Every result carries
// the hit, miss, cached and dirty counters as they stand after the request.
// All per-slot state sits in one synchronous memory with a registered read;
// a sequencer reads, modifies and writes it back. Release and mark dirty
// read the named slot and update it; a get scans the slots until it finds
// a match, walks the LRU list from the oldest entry when a victim must be
// found, and then puts the slot at the front of the list; an invalidate
// scans all slots to count matches and then visits each slot again. Only one request
// is in flight, so throughput is set by the slot scan through the single
// memory read port. After reset the block clears every slot of the
// memory, with in_req.ready low. A result waits in the output register
// while out_rsp.ready is low; the sequencer then pauses, but a new request
// can be taken as soon as the last result of the previous one is loaded.
module lru_block_buffer_cache import lbc_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  lbc_req_if.sink    in_req,
  lbc_rsp_if.source  out_rsp
);

  entry_t mem [CACHE_SLOTS];
  entry_t rdata_r;

  st_t state_r, state_nxt, ret_r, ret_nxt;
  op_t op_r, op_nxt;

  logic [2:0]    cmd_r, cmd_nxt;
  logic [3:0]    dev_r, dev_nxt;
  logic [31:0]   blk_r, blk_nxt;
  logic [SW-1:0] slot_r, slot_nxt;
  logic [LW-1:0] idx_r, idx_nxt;
  logic [LW-1:0] guard_r, guard_nxt;
  logic [LW-1:0] walk_r, walk_nxt;
  logic [SW-1:0] tgt_r, tgt_nxt;
  logic [LW-1:0] nw_r, nw_nxt;
  logic [LW-1:0] od_r, od_nxt;
  entry_t        info_r, info_nxt;
  logic [CW-1:0] cu_r, cu_nxt;
  logic [CW-1:0] cd_r, cd_nxt;
  logic [LW-1:0] front_r, front_nxt;
  logic [LW-1:0] back_r, back_nxt;
  logic [LW-1:0] ftop_r, ftop_nxt;
  logic [31:0]   hits_r, hits_nxt;
  logic [31:0]   miss_r, miss_nxt;
  logic [CW-1:0] cached_r, cached_nxt;
  logic [CW-1:0] dirty_r, dirty_nxt;

  // Pending result, loaded into the output register by the emit state.
  logic [2:0]  em_kind_r, em_kind_nxt;
  logic [4:0]  em_slot_r, em_slot_nxt;
  logic [3:0]  em_dev_r, em_dev_nxt;
  logic [31:0] em_blk_r, em_blk_nxt;
  logic        em_last_r, em_last_nxt;

  logic          rv_r;
  logic [SW-1:0] ra_r;
  logic          ov_r, ov_nxt;
  logic [2:0]    o_kind_r, o_kind_nxt;
  logic [4:0]    o_slot_r, o_slot_nxt;
  logic [3:0]    o_dev_r, o_dev_nxt;
  logic [31:0]   o_blk_r, o_blk_nxt;
  logic          o_last_r, o_last_nxt;
  logic [31:0]   o_hits_r, o_hits_nxt;
  logic [31:0]   o_miss_r, o_miss_nxt;
  logic [CW-1:0] o_cached_r, o_cached_nxt;
  logic [CW-1:0] o_dirty_r, o_dirty_nxt;

  logic          rd_en;
  logic [SW-1:0] rd_addr;
  logic          we_info, we_new, we_old, we_fl;
  logic [SW-1:0] wa;
  entry_t        wd;

  // Shared decode.
  logic accept, is_get, in_dev_ok, in_slot_ok, out_free;
  logic scan_hit, scan_last, inv_match, evictable, idx_last;
  logic ftop_ok, walk_ok, front_ok, nw_ok, od_ok, hit_at_front;

  assign accept     = in_req.valid && in_req.ready;
  assign is_get     = (cmd_r == CMD_GET) || (cmd_r == CMD_GET_NF);
  assign in_dev_ok  = int'(in_req.device_id) < DEVICE_COUNT;
  assign in_slot_ok = int'(in_req.slot) < CACHE_SLOTS;
  assign out_free   = !ov_r || out_rsp.ready;
  assign scan_hit   = rv_r && rdata_r.flags[FL_USE] && (rdata_r.dev == dev_r) &&
                      (rdata_r.blk == blk_r);
  assign scan_last  = rv_r && (ra_r == SW'(CACHE_SLOTS - 1));
  assign inv_match  = rdata_r.flags[FL_USE] && (rdata_r.dev == dev_r);
  assign evictable  = !rdata_r.flags[FL_BUSY] && (rdata_r.refs == '0);
  assign idx_last   = idx_r == LW'(CACHE_SLOTS - 1);
  assign ftop_ok    = int'(ftop_r) < CACHE_SLOTS;
  assign walk_ok    = (int'(walk_r) < CACHE_SLOTS) && (int'(guard_r) < CACHE_SLOTS);
  assign front_ok   = int'(front_r) < CACHE_SLOTS;
  assign nw_ok      = int'(nw_r) < CACHE_SLOTS;
  assign od_ok      = int'(od_r) < CACHE_SLOTS;
  assign hit_at_front = front_r == LW'(ra_r);

  assign in_req.ready = (state_r == ST_IDLE);

  assign out_rsp.valid        = ov_r;
  assign out_rsp.kind         = o_kind_r;
  assign out_rsp.out_slot     = o_slot_r;
  assign out_rsp.out_device   = o_dev_r;
  assign out_rsp.out_block    = o_blk_r;
  assign out_rsp.last         = o_last_r;
  assign out_rsp.hit_count    = o_hits_r;
  assign out_rsp.miss_count   = o_miss_r;
  assign out_rsp.cached_count = o_cached_r;
  assign out_rsp.dirty_count  = o_dirty_r;

  // Slot memory: one read port with registered data, one write port with
  // separate enables for the record, the two LRU links and the free link.
  always_ff @(posedge clk) begin
    if (we_info) begin
      mem[wa].dev   <= wd.dev;
      mem[wa].blk   <= wd.blk;
      mem[wa].flags <= wd.flags;
      mem[wa].refs  <= wd.refs;
    end
    if (we_new) begin
      mem[wa].newer <= wd.newer;
    end
    if (we_old) begin
      mem[wa].older <= wd.older;
    end
    if (we_fl) begin
      mem[wa].flink <= wd.flink;
    end
    if (rd_en) begin
      rdata_r <= mem[rd_addr];
    end
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_CLEAR: begin
        if (idx_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (in_req.command)
            CMD_GET, CMD_GET_NF, CMD_INVAL: state_nxt = in_dev_ok ? ST_SCAN : ST_EMIT;
            CMD_RELEASE, CMD_DIRTY:         state_nxt = in_slot_ok ? ST_SLOT_CHK : ST_EMIT;
            default:                        state_nxt = ST_EMIT;
          endcase
        end
      end
      ST_SCAN: begin
        if (is_get) begin
          if (scan_hit) begin
            state_nxt = hit_at_front ? ST_EMIT : ST_UNL_A;
          end else if (scan_last) begin
            state_nxt = ftop_ok ? ST_FREE_RD : ST_EVICT_RD;
          end
        end else if (scan_last) begin
          state_nxt = ST_INV_RD;
        end
      end
      ST_FREE_RD:  state_nxt = ST_PUSH;
      ST_EVICT_RD: state_nxt = walk_ok ? ST_EVICT_CHK : ST_EMIT;
      ST_EVICT_CHK: begin
        if (evictable) begin
          state_nxt = rdata_r.flags[FL_DIRTY] ? ST_EMIT : ST_UNL_A;
        end else begin
          state_nxt = ST_EVICT_RD;
        end
      end
      ST_SLOT_CHK: state_nxt = ST_EMIT;
      ST_INV_RD:   state_nxt = ST_INV_CHK;
      ST_INV_CHK: begin
        if (inv_match) begin
          state_nxt = rdata_r.flags[FL_DIRTY] ? ST_EMIT : ST_UNL_A;
        end else begin
          state_nxt = idx_last ? ST_EMIT : ST_INV_RD;
        end
      end
      ST_UNL_A:    state_nxt = ST_UNL_B;
      ST_UNL_B:    state_nxt = (op_r == OP_INV) ? ST_INV_FREE : ST_PUSH;
      ST_PUSH:     state_nxt = ST_FRONT;
      ST_FRONT:    state_nxt = ST_EMIT;
      ST_INV_FREE: state_nxt = idx_last ? ST_EMIT : ST_INV_RD;
      ST_EMIT: begin
        if (out_free) state_nxt = em_last_r ? ST_IDLE : ret_r;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Datapath, memory controls and output register.
  always_comb begin
    ret_nxt      = ret_r;
    op_nxt       = op_r;
    cmd_nxt      = cmd_r;
    dev_nxt      = dev_r;
    blk_nxt      = blk_r;
    slot_nxt     = slot_r;
    idx_nxt      = idx_r;
    guard_nxt    = guard_r;
    walk_nxt     = walk_r;
    tgt_nxt      = tgt_r;
    nw_nxt       = nw_r;
    od_nxt       = od_r;
    info_nxt     = info_r;
    cu_nxt       = cu_r;
    cd_nxt       = cd_r;
    front_nxt    = front_r;
    back_nxt     = back_r;
    ftop_nxt     = ftop_r;
    hits_nxt     = hits_r;
    miss_nxt     = miss_r;
    cached_nxt   = cached_r;
    dirty_nxt    = dirty_r;
    em_kind_nxt  = em_kind_r;
    em_slot_nxt  = em_slot_r;
    em_dev_nxt   = em_dev_r;
    em_blk_nxt   = em_blk_r;
    em_last_nxt  = em_last_r;
    ov_nxt       = ov_r && !out_rsp.ready;
    o_kind_nxt   = o_kind_r;
    o_slot_nxt   = o_slot_r;
    o_dev_nxt    = o_dev_r;
    o_blk_nxt    = o_blk_r;
    o_last_nxt   = o_last_r;
    o_hits_nxt   = o_hits_r;
    o_miss_nxt   = o_miss_r;
    o_cached_nxt = o_cached_r;
    o_dirty_nxt  = o_dirty_r;
    rd_en        = 1'b0;
    rd_addr      = idx_r[SW-1:0];
    we_info      = 1'b0;
    we_new       = 1'b0;
    we_old       = 1'b0;
    we_fl        = 1'b0;
    wa           = tgt_r;
    wd           = info_r;

    case (state_r)
      ST_CLEAR: begin
        we_info  = 1'b1;
        we_new   = 1'b1;
        we_old   = 1'b1;
        we_fl    = 1'b1;
        wa       = idx_r[SW-1:0];
        wd       = '0;
        wd.newer = NIL;
        wd.older = NIL;
        wd.flink = idx_last ? NIL : idx_r + LW'(1);
        idx_nxt  = idx_r + LW'(1);
      end
      ST_IDLE: begin
        if (accept) begin
          cmd_nxt     = in_req.command;
          dev_nxt     = in_req.device_id;
          blk_nxt     = in_req.block_number;
          slot_nxt    = SW'(in_req.slot);
          idx_nxt     = '0;
          cu_nxt      = '0;
          cd_nxt      = '0;
          em_last_nxt = 1'b1;
          em_kind_nxt = KIND_DONE;
          em_slot_nxt = '0;
          em_dev_nxt  = '0;
          em_blk_nxt  = '0;
          case (in_req.command)
            CMD_GET, CMD_GET_NF: begin
              em_kind_nxt = KIND_NOSLOT;
              em_dev_nxt  = in_req.device_id;
              em_blk_nxt  = in_req.block_number;
            end
            CMD_RELEASE, CMD_DIRTY: begin
              em_slot_nxt = in_req.slot;
              rd_en       = in_slot_ok;
              rd_addr     = SW'(in_req.slot);
            end
            default: begin
            end
          endcase
        end
      end
      ST_SCAN: begin
        if (int'(idx_r) < CACHE_SLOTS) begin
          rd_en   = 1'b1;
          idx_nxt = idx_r + LW'(1);
        end
        if (is_get) begin
          if (scan_hit) begin
            info_nxt = rdata_r;
            if (int'(rdata_r.refs) < REF_MAX) info_nxt.refs = rdata_r.refs + RW'(1);
            info_nxt.flags[FL_BUSY]  = 1'b1;
            info_nxt.flags[FL_VALID] = 1'b1;
            tgt_nxt = ra_r;
            nw_nxt  = rdata_r.newer;
            od_nxt  = rdata_r.older;
            op_nxt  = OP_HIT;
            if (cmd_r == CMD_GET) hits_nxt = hits_r + 32'd1;
            em_kind_nxt = KIND_HIT;
            em_slot_nxt = 5'(ra_r);
            em_dev_nxt  = dev_r;
            em_blk_nxt  = blk_r;
            em_last_nxt = 1'b1;
            if (hit_at_front) begin
              we_info = 1'b1;
              wa      = ra_r;
              wd      = info_nxt;
            end
          end else if (scan_last) begin
            if (cmd_r == CMD_GET) miss_nxt = miss_r + 32'd1;
            info_nxt       = '0;
            info_nxt.dev   = dev_r;
            info_nxt.blk   = blk_r;
            info_nxt.refs  = RW'(1);
            info_nxt.flags[FL_USE]   = 1'b1;
            info_nxt.flags[FL_VALID] = 1'b1;
            info_nxt.flags[FL_BUSY]  = 1'b1;
            op_nxt = OP_BIND;
            if (ftop_ok) begin
              rd_en      = 1'b1;
              rd_addr    = ftop_r[SW-1:0];
              tgt_nxt    = ftop_r[SW-1:0];
              cached_nxt = cached_r + CW'(1);
            end else begin
              walk_nxt  = back_r;
              guard_nxt = '0;
            end
          end
        end else begin
          if (rv_r && inv_match) begin
            cu_nxt = cu_r + CW'(1);
            if (rdata_r.flags[FL_DIRTY]) cd_nxt = cd_r + CW'(1);
          end
          if (scan_last) begin
            cached_nxt = cached_r - cu_nxt;
            dirty_nxt  = dirty_r - cd_nxt;
            idx_nxt    = '0;
          end
        end
      end
      ST_FREE_RD: begin
        ftop_nxt = rdata_r.flink;
      end
      ST_EVICT_RD: begin
        if (walk_ok) begin
          rd_en   = 1'b1;
          rd_addr = walk_r[SW-1:0];
        end
      end
      ST_EVICT_CHK: begin
        if (evictable) begin
          tgt_nxt = walk_r[SW-1:0];
          nw_nxt  = rdata_r.newer;
          od_nxt  = rdata_r.older;
          if (rdata_r.flags[FL_DIRTY]) begin
            dirty_nxt   = dirty_r - CW'(1);
            em_kind_nxt = KIND_WB;
            em_slot_nxt = 5'(walk_r[SW-1:0]);
            em_dev_nxt  = rdata_r.dev;
            em_blk_nxt  = rdata_r.blk;
            em_last_nxt = 1'b0;
            ret_nxt     = ST_UNL_A;
          end
        end else begin
          walk_nxt  = rdata_r.newer;
          guard_nxt = guard_r + LW'(1);
        end
      end
      ST_SLOT_CHK: begin
        wd = rdata_r;
        wa = slot_r;
        if (cmd_r == CMD_RELEASE) begin
          if (rdata_r.refs != '0) wd.refs = rdata_r.refs - RW'(1);
          wd.flags[FL_BUSY] = 1'b0;
          we_info = 1'b1;
        end else if (rdata_r.flags[FL_USE] && !rdata_r.flags[FL_DIRTY]) begin
          wd.flags[FL_DIRTY] = 1'b1;
          we_info   = 1'b1;
          dirty_nxt = dirty_r + CW'(1);
        end
      end
      ST_INV_RD: begin
        rd_en = 1'b1;
      end
      ST_INV_CHK: begin
        if (inv_match) begin
          tgt_nxt = idx_r[SW-1:0];
          nw_nxt  = rdata_r.newer;
          od_nxt  = rdata_r.older;
          op_nxt  = OP_INV;
          if (rdata_r.flags[FL_DIRTY]) begin
            em_kind_nxt = KIND_WB;
            em_slot_nxt = 5'(idx_r[SW-1:0]);
            em_dev_nxt  = rdata_r.dev;
            em_blk_nxt  = rdata_r.blk;
            em_last_nxt = 1'b0;
            ret_nxt     = ST_UNL_A;
          end
        end else if (idx_last) begin
          em_kind_nxt = KIND_DONE;
          em_slot_nxt = '0;
          em_dev_nxt  = '0;
          em_blk_nxt  = '0;
          em_last_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + LW'(1);
        end
      end
      ST_UNL_A: begin
        if (nw_ok) begin
          we_old   = 1'b1;
          wa       = nw_r[SW-1:0];
          wd.older = od_r;
        end else begin
          front_nxt = od_r;
        end
      end
      ST_UNL_B: begin
        if (od_ok) begin
          we_new   = 1'b1;
          wa       = od_r[SW-1:0];
          wd.newer = nw_r;
        end else begin
          back_nxt = nw_r;
        end
      end
      ST_PUSH: begin
        we_info  = 1'b1;
        we_new   = 1'b1;
        we_old   = 1'b1;
        wd.newer = NIL;
        wd.older = front_r;
      end
      ST_FRONT: begin
        if (front_ok) begin
          we_new   = 1'b1;
          wa       = front_r[SW-1:0];
          wd.newer = LW'(tgt_r);
        end else begin
          back_nxt = LW'(tgt_r);
        end
        front_nxt   = LW'(tgt_r);
        em_kind_nxt = (op_r == OP_HIT) ? KIND_HIT :
                      (cmd_r == CMD_GET) ? KIND_FILL : KIND_ALLOC;
        em_slot_nxt = 5'(tgt_r);
        em_dev_nxt  = dev_r;
        em_blk_nxt  = blk_r;
        em_last_nxt = 1'b1;
      end
      ST_INV_FREE: begin
        we_info  = 1'b1;
        we_fl    = 1'b1;
        wd       = '0;
        wd.flink = ftop_r;
        ftop_nxt = LW'(tgt_r);
        if (idx_last) begin
          em_kind_nxt = KIND_DONE;
          em_slot_nxt = '0;
          em_dev_nxt  = '0;
          em_blk_nxt  = '0;
          em_last_nxt = 1'b1;
        end else begin
          idx_nxt = idx_r + LW'(1);
        end
      end
      ST_EMIT: begin
        if (out_free) begin
          ov_nxt       = 1'b1;
          o_kind_nxt   = em_kind_r;
          o_slot_nxt   = em_slot_r;
          o_dev_nxt    = em_dev_r;
          o_blk_nxt    = em_blk_r;
          o_last_nxt   = em_last_r;
          o_hits_nxt   = hits_r;
          o_miss_nxt   = miss_r;
          o_cached_nxt = cached_r;
          o_dirty_nxt  = dirty_r;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= ST_CLEAR;
      idx_r    <= '0;
      rv_r     <= 1'b0;
      ov_r     <= 1'b0;
      front_r  <= NIL;
      back_r   <= NIL;
      ftop_r   <= '0;
      hits_r   <= '0;
      miss_r   <= '0;
      cached_r <= '0;
      dirty_r  <= '0;
    end else begin
      state_r  <= state_nxt;
      idx_r    <= idx_nxt;
      rv_r     <= rd_en;
      ov_r     <= ov_nxt;
      front_r  <= front_nxt;
      back_r   <= back_nxt;
      ftop_r   <= ftop_nxt;
      hits_r   <= hits_nxt;
      miss_r   <= miss_nxt;
      cached_r <= cached_nxt;
      dirty_r  <= dirty_nxt;
    end
  end

  always_ff @(posedge clk) begin
    ra_r       <= rd_addr;
    ret_r      <= ret_nxt;
    op_r       <= op_nxt;
    cmd_r      <= cmd_nxt;
    dev_r      <= dev_nxt;
    blk_r      <= blk_nxt;
    slot_r     <= slot_nxt;
    guard_r    <= guard_nxt;
    walk_r     <= walk_nxt;
    tgt_r      <= tgt_nxt;
    nw_r       <= nw_nxt;
    od_r       <= od_nxt;
    info_r     <= info_nxt;
    cu_r       <= cu_nxt;
    cd_r       <= cd_nxt;
    em_kind_r  <= em_kind_nxt;
    em_slot_r  <= em_slot_nxt;
    em_dev_r   <= em_dev_nxt;
    em_blk_r   <= em_blk_nxt;
    em_last_r  <= em_last_nxt;
    o_kind_r   <= o_kind_nxt;
    o_slot_r   <= o_slot_nxt;
    o_dev_r    <= o_dev_nxt;
    o_blk_r    <= o_blk_nxt;
    o_last_r   <= o_last_nxt;
    o_hits_r   <= o_hits_nxt;
    o_miss_r   <= o_miss_nxt;
    o_cached_r <= o_cached_nxt;
    o_dirty_r  <= o_dirty_nxt;
  end

endmodule

>>> rtl/core/lbc_chk.sv
module lbc_chk import lbc_pkg::*; (
  input logic          clk,
  input logic          rst_n,
  input logic          in_valid,
  input logic          in_ready,
  input logic          out_valid,
  input logic          out_ready,
  input logic [2:0]    kind,
  input logic [4:0]    out_slot,
  input logic          last,
  input logic [CW-1:0] cached_count,
  input logic [CW-1:0] dirty_count
);

  // A result held back by the receiver keeps its kind, slot and last flag.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(kind) && $stable(out_slot) && $stable(last))
    else $error("result changed while stalled");

  // Only one request is worked on at a time.
  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("request taken while another is in progress");

  a_counts: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> int'(cached_count) <= CACHE_SLOTS && dirty_count <= cached_count)
    else $error("slot counters out of range");

  a_wb_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_WB |-> !last)
    else $error("writeback flagged as final result");

  a_noslot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && kind == KIND_NOSLOT |-> last && out_slot == '0)
    else $error("no-slot result malformed");

endmodule

bind lru_block_buffer_cache lbc_chk u_lbc_chk (
  .clk          (clk),
  .rst_n        (rst_n),
  .in_valid     (in_req.valid),
  .in_ready     (in_req.ready),
  .out_valid    (out_rsp.valid),
  .out_ready    (out_rsp.ready),
  .kind         (out_rsp.kind),
  .out_slot     (out_rsp.out_slot),
  .last         (out_rsp.last),
  .cached_count (out_rsp.cached_count),
  .dirty_count  (out_rsp.dirty_count)
);
